FILE: rtl/qmu_pkg.sv
// Shared types, constants and helpers for the quaternion math unit.
// No dependencies; used by every module of the block.
`default_nettype none

package qmu_pkg;

    localparam int OP_W   = 34;   // operand width: Q2.30 CORDIC values and sign-extended words
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = PROD_W + 3;

    typedef logic signed [OP_W-1:0] t_op;
    typedef logic signed [31:0]     t_word;

    localparam t_op CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [1:0] {
        KIND_EULER    = 2'd0,
        KIND_HAMILTON = 2'd1,
        KIND_ROTATE   = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SH_30,
        SH_FRAC,
        SH_FRAC_M1,
        SH_EULER
    } t_shift;

    typedef struct packed {
        t_kind            kind;
        logic [3:0][31:0] q;      // x, y, z, w at indexes 0..3
        logic [3:0][31:0] o;
    } t_side;

    typedef struct packed {
        t_side side;
        t_op   cr;
        t_op   sr;
    } t_post;

    typedef struct packed {
        t_kind            kind;
        logic [3:0][31:0] res;
        logic             ovf;
    } t_fin;

    // atan(2^-i) in phase units, 2^32 per turn
    function automatic t_op f_atan(input int unsigned idx);
        t_op v;
        case (idx)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            24: v = 34'sd41;
            25: v = 34'sd20;
            26: v = 34'sd10;
            27: v = 34'sd5;
            28: v = 34'sd3;
            29: v = 34'sd1;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_op f_sx(input logic [31:0] v);
        return {{(OP_W-32){v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/qmu_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a half angle.
// One stage per iteration; depends on qmu_pkg.
`default_nettype none

module qmu_cordic
    import qmu_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_angle,
    output t_op         o_sin,
    output t_op         o_cos
);

    t_op  r_x    [STEPS];
    t_op  r_y    [STEPS];
    t_op  r_z    [STEPS];
    logic r_flip [STEPS];

    logic [31:0] ph;
    logic [31:0] ph_t;
    logic [31:0] ph_f;
    logic        pre_flip;
    t_op         pre_z;

    // fold the phase into the right half plane, negate the result afterwards
    always_comb begin
        ph       = {i_angle, 15'b0};
        ph_t     = ph + 32'h4000_0000;
        pre_flip = ph_t[31];
        ph_f     = pre_flip ? (ph - 32'h8000_0000) : ph;
        pre_z    = f_sx(ph_f);
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        t_op  x_in, y_in, z_in;
        logic f_in;
        t_op  n_x, n_y, n_z;

        if (g == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = pre_z;
            assign f_in = pre_flip;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
            assign f_in = r_flip[g-1];
        end

        always_comb begin
            if (!z_in[OP_W-1]) begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - f_atan(g);
            end else begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + f_atan(g);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= n_x;
                r_y[g]    <= n_y;
                r_z[g]    <= n_z;
                r_flip[g] <= f_in;
            end
        end
    end

    assign o_sin = r_flip[STEPS-1] ? -r_y[STEPS-1] : r_y[STEPS-1];
    assign o_cos = r_flip[STEPS-1] ? -r_x[STEPS-1] : r_x[STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/qmu_dot.sv
// One lane: sum of four signed products, each added or subtracted, plus offset,
// rounded and saturated; products and result are registered. Depends on qmu_pkg.
`default_nettype none

module qmu_dot
    import qmu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  t_op                             i_a [4],
    input  t_op                             i_b [4],
    input  logic [3:0]                      i_neg,
    input  logic signed [32+FRAC_BITS-1:0]  i_off,
    input  t_shift                          i_shift,
    output t_word                           o_res,
    output logic                            o_ovf
);

    localparam int OFF_W = 32 + FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF_30   = ACC_W'(1) <<< 29;
    localparam logic signed [ACC_W-1:0] HALF_F    = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] HALF_FM1  = ACC_W'(1) <<< (FRAC_BITS - 2);
    localparam logic signed [ACC_W-1:0] HALF_E    = ACC_W'(1) <<< (59 - FRAC_BITS);
    localparam logic signed [ACC_W-1:0] SAT_MAX   = 71'sd2147483647;
    localparam logic signed [ACC_W-1:0] SAT_MIN   = -71'sd2147483648;

    logic signed [PROD_W-1:0] r_p [4];
    logic [3:0]               r_neg;
    logic signed [OFF_W-1:0]  r_off;
    t_shift                   r_shift;
    t_word                    r_res;
    logic                     r_ovf;

    logic signed [ACC_W-1:0]  n_sum;
    logic signed [ACC_W-1:0]  n_ext;
    logic signed [ACC_W-1:0]  n_rnd;
    t_word                    n_res;
    logic                     n_ovf;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= i_a[k] * i_b[k];
            end
            r_neg   <= i_neg;
            r_off   <= i_off;
            r_shift <= i_shift;
            r_res   <= n_res;
            r_ovf   <= n_ovf;
        end
    end

    always_comb begin
        n_sum = {{(ACC_W-OFF_W){r_off[OFF_W-1]}}, r_off};
        n_ext = '0;
        for (int k = 0; k < 4; k++) begin
            n_ext = {{(ACC_W-PROD_W){r_p[k][PROD_W-1]}}, r_p[k]};
            n_sum = r_neg[k] ? (n_sum - n_ext) : (n_sum + n_ext);
        end
        // round to nearest, ties up
        case (r_shift)
            SH_30:      n_rnd = (n_sum + HALF_30) >>> 30;
            SH_FRAC:    n_rnd = (n_sum + HALF_F) >>> FRAC_BITS;
            SH_FRAC_M1: n_rnd = (n_sum + HALF_FM1) >>> (FRAC_BITS - 1);
            SH_EULER:   n_rnd = (n_sum + HALF_E) >>> (60 - FRAC_BITS);
            default:    n_rnd = '0;
        endcase
        if (n_rnd > SAT_MAX) begin
            n_res = 32'sh7FFF_FFFF;
            n_ovf = 1'b1;
        end else if (n_rnd < SAT_MIN) begin
            n_res = 32'sh8000_0000;
            n_ovf = 1'b1;
        end else begin
            n_res = n_rnd[31:0];
            n_ovf = 1'b0;
        end
    end

    assign o_res = r_res;
    assign o_ovf = r_ovf;

endmodule

`default_nettype wire

FILE: rtl/quaternion_math_unit.sv
// Quaternion math unit top level: three CORDIC lanes, two rounds of four dot lanes.
// Depends on qmu_pkg, qmu_cordic and qmu_dot.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+---------------------------------------------
//  input   | i_valid | o_ready | i_kind, i_*_angle, i_quat_*, i_other_*
//  output  | o_valid | i_ready | o_out_x/y/z/w, o_overflow
//
// One request per cycle sustained while the output is not stalled. The pipeline has one
// stage per CORDIC iteration, then a product and a result register in each dot round.
// Synchronous active-low reset clears the stage valid bits only.
// A stall at the output freezes every stage at once; o_ready = !o_valid || i_ready.
`default_nettype none

module quaternion_math_unit
    import qmu_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic [15:0]        i_yaw_angle,
    input  logic [15:0]        i_pitch_angle,
    input  logic [15:0]        i_roll_angle,
    input  logic signed [31:0] i_quat_x,
    input  logic signed [31:0] i_quat_y,
    input  logic signed [31:0] i_quat_z,
    input  logic signed [31:0] i_quat_w,
    input  logic signed [31:0] i_other_x,
    input  logic signed [31:0] i_other_y,
    input  logic signed [31:0] i_other_z,
    input  logic signed [31:0] i_other_w,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w,
    output logic               o_overflow
);

    localparam int LAT = CORDIC_STEPS + 4;

    logic           en;
    logic           accept;
    logic [LAT-1:0] r_vld;
    t_side          in_side;
    t_side          r_side [CORDIC_STEPS];
    t_side          sd;
    t_post          n_post;
    t_post          r_post [2];
    t_fin           n_fin;
    t_fin           r_fin  [2];
    t_fin           fin;

    t_op yaw_sin, yaw_cos, pitch_sin, pitch_cos, roll_sin, roll_cos;
    t_op qx, qy, qz, qw, ox, oy, oz, ow;
    t_op bqx, bqy, bqz, bqw, ra0, ra1, ra2, ra3;

    t_op                            a_a   [4][4];
    t_op                            a_b   [4][4];
    logic [3:0]                     neg_a [4];
    t_shift                         sh_a;
    t_op                            b_a   [4][4];
    t_op                            b_b   [4][4];
    logic [3:0]                     neg_b [4];
    logic signed [32+FRAC_BITS-1:0] off_b [4];
    logic signed [32+FRAC_BITS-1:0] off_zero;
    t_shift                         sh_b;
    t_word                          res_a [4];
    t_word                          res_b [4];
    logic [3:0]                     ovf_a;
    logic [3:0]                     ovf_b;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign accept  = i_valid && en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    always_comb begin
        in_side.kind = t_kind'(i_kind);
        in_side.q    = {i_quat_w, i_quat_z, i_quat_y, i_quat_x};
        in_side.o    = {i_other_w, i_other_z, i_other_y, i_other_x};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= in_side;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_post[0] <= n_post;
            r_post[1] <= r_post[0];
            r_fin[0]  <= n_fin;
            r_fin[1]  <= r_fin[0];
        end
    end

    qmu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
        .i_clk(i_clk), .i_en(en), .i_angle(i_yaw_angle), .o_sin(yaw_sin), .o_cos(yaw_cos)
    );
    qmu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .i_clk(i_clk), .i_en(en), .i_angle(i_pitch_angle),
        .o_sin(pitch_sin), .o_cos(pitch_cos)
    );
    qmu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .i_clk(i_clk), .i_en(en), .i_angle(i_roll_angle), .o_sin(roll_sin), .o_cos(roll_cos)
    );

    assign sd  = r_side[CORDIC_STEPS-1];
    assign qx  = f_sx(sd.q[0]);
    assign qy  = f_sx(sd.q[1]);
    assign qz  = f_sx(sd.q[2]);
    assign qw  = f_sx(sd.q[3]);
    assign ox  = f_sx(sd.o[0]);
    assign oy  = f_sx(sd.o[1]);
    assign oz  = f_sx(sd.o[2]);
    assign ow  = f_sx(sd.o[3]);
    assign bqx = f_sx(r_post[1].side.q[0]);
    assign bqy = f_sx(r_post[1].side.q[1]);
    assign bqz = f_sx(r_post[1].side.q[2]);
    assign bqw = f_sx(r_post[1].side.q[3]);
    assign ra0 = f_sx(res_a[0]);
    assign ra1 = f_sx(res_a[1]);
    assign ra2 = f_sx(res_a[2]);
    assign ra3 = f_sx(res_a[3]);
    assign off_zero = '0;

    always_comb begin
        n_post.side = sd;
        n_post.cr   = roll_cos;
        n_post.sr   = roll_sin;
        n_fin.kind  = r_post[1].side.kind;
        for (int k = 0; k < 4; k++) begin
            n_fin.res[k] = res_a[k];
        end
        n_fin.ovf = |ovf_a;
    end

    // first round: half-angle pair products, Hamilton sums, or the cross term t
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            neg_a[i] = '0;
            for (int j = 0; j < 4; j++) begin
                a_a[i][j] = '0;
                a_b[i][j] = '0;
            end
        end
        sh_a = SH_FRAC;
        case (sd.kind)
            KIND_EULER: begin
                sh_a = SH_30;
                a_a[0][0] = yaw_cos; a_b[0][0] = pitch_sin;
                a_a[1][0] = yaw_sin; a_b[1][0] = pitch_cos;
                a_a[2][0] = yaw_cos; a_b[2][0] = pitch_cos;
                a_a[3][0] = yaw_sin; a_b[3][0] = pitch_sin;
            end
            KIND_HAMILTON: begin
                a_a[0] = '{qw, qx, qy, qz}; a_b[0] = '{ox, ow, oz, oy}; neg_a[0] = 4'b1000;
                a_a[1] = '{qw, qx, qy, qz}; a_b[1] = '{oy, oz, ow, ox}; neg_a[1] = 4'b0010;
                a_a[2] = '{qw, qx, qy, qz}; a_b[2] = '{oz, oy, ox, ow}; neg_a[2] = 4'b0100;
                a_a[3] = '{qw, qx, qy, qz}; a_b[3] = '{ow, ox, oy, oz}; neg_a[3] = 4'b1110;
            end
            KIND_ROTATE: begin
                sh_a = SH_FRAC_M1;
                a_a[0][0] = qy; a_b[0][0] = oz; a_a[0][1] = qz; a_b[0][1] = oy;
                a_a[1][0] = qz; a_b[1][0] = ox; a_a[1][1] = qx; a_b[1][1] = oz;
                a_a[2][0] = qx; a_b[2][0] = oy; a_a[2][1] = qy; a_b[2][1] = ox;
                neg_a[0] = 4'b0010;
                neg_a[1] = 4'b0010;
                neg_a[2] = 4'b0010;
            end
            default: ;
        endcase
    end

    // second round: roll products for euler, v + w*t + q x t for rotation
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            neg_b[i] = '0;
            off_b[i] = '0;
            for (int j = 0; j < 4; j++) begin
                b_a[i][j] = '0;
                b_b[i][j] = '0;
            end
        end
        sh_b = SH_FRAC;
        case (r_post[1].side.kind)
            KIND_EULER: begin
                sh_b = SH_EULER;
                b_a[0][0] = ra0; b_b[0][0] = r_post[1].cr;
                b_a[0][1] = ra1; b_b[0][1] = r_post[1].sr;
                b_a[1][0] = ra1; b_b[1][0] = r_post[1].cr;
                b_a[1][1] = ra0; b_b[1][1] = r_post[1].sr;
                b_a[2][0] = ra2; b_b[2][0] = r_post[1].sr;
                b_a[2][1] = ra3; b_b[2][1] = r_post[1].cr;
                b_a[3][0] = ra2; b_b[3][0] = r_post[1].cr;
                b_a[3][1] = ra3; b_b[3][1] = r_post[1].sr;
                neg_b[1] = 4'b0010;
                neg_b[2] = 4'b0010;
            end
            KIND_ROTATE: begin
                off_b[0] = {r_post[1].side.o[0], {FRAC_BITS{1'b0}}};
                off_b[1] = {r_post[1].side.o[1], {FRAC_BITS{1'b0}}};
                off_b[2] = {r_post[1].side.o[2], {FRAC_BITS{1'b0}}};
                b_a[0][0] = ra0; b_b[0][0] = bqw;
                b_a[0][1] = bqy; b_b[0][1] = ra2;
                b_a[0][2] = bqz; b_b[0][2] = ra1;
                b_a[1][0] = ra1; b_b[1][0] = bqw;
                b_a[1][1] = bqz; b_b[1][1] = ra0;
                b_a[1][2] = bqx; b_b[1][2] = ra2;
                b_a[2][0] = ra2; b_b[2][0] = bqw;
                b_a[2][1] = bqx; b_b[2][1] = ra1;
                b_a[2][2] = bqy; b_b[2][2] = ra0;
                neg_b[0] = 4'b0100;
                neg_b[1] = 4'b0100;
                neg_b[2] = 4'b0100;
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        qmu_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_a (
            .i_clk(i_clk), .i_en(en), .i_a(a_a[g]), .i_b(a_b[g]), .i_neg(neg_a[g]),
            .i_off(off_zero), .i_shift(sh_a), .o_res(res_a[g]), .o_ovf(ovf_a[g])
        );
        qmu_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_b (
            .i_clk(i_clk), .i_en(en), .i_a(b_a[g]), .i_b(b_b[g]), .i_neg(neg_b[g]),
            .i_off(off_b[g]), .i_shift(sh_b), .o_res(res_b[g]), .o_ovf(ovf_b[g])
        );
    end

    assign fin        = r_fin[1];
    assign o_out_x    = (fin.kind == KIND_HAMILTON) ? $signed(fin.res[0]) : res_b[0];
    assign o_out_y    = (fin.kind == KIND_HAMILTON) ? $signed(fin.res[1]) : res_b[1];
    assign o_out_z    = (fin.kind == KIND_HAMILTON) ? $signed(fin.res[2]) : res_b[2];
    assign o_out_w    = (fin.kind == KIND_HAMILTON) ? $signed(fin.res[3]) : res_b[3];
    assign o_overflow = fin.ovf | (|ovf_b);

`ifndef SYNTHESIS
    a_rotate_w_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && fin.kind == KIND_ROTATE |-> o_out_w == 32'sd0)
        else $error("rotation result has nonzero w");
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && fin.kind == KIND_UNUSED |->
            o_out_x == 32'sd0 && o_out_y == 32'sd0 && o_out_z == 32'sd0 &&
            o_out_w == 32'sd0 && !o_overflow)
        else $error("unused kind produced nonzero result");
    a_euler_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && fin.kind == KIND_EULER |-> !o_overflow)
        else $error("euler conversion saturated");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for quaternion_math_unit: directed table, then random requests.
// Depends on qmu_pkg and the quaternion_math_unit RTL; expected values come from a local predictor or typed rows.
module tb;
    import qmu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int FB = 16;
    localparam int N_RANDOM = 1200;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0] kind;
        logic [15:0] yaw, pitch, roll;
        logic [31:0] q[4];
        logic [31:0] o[4];
    } t_req;

    typedef struct {
        logic [31:0] v[4];
        logic ovf;
        bit typed;   // true when the row carries a hand-typed answer
    } t_res;

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_ready = 0;
    logic o_ready, o_valid, o_overflow;
    logic [1:0] i_kind = 0;
    logic [15:0] i_yaw_angle = 0, i_pitch_angle = 0, i_roll_angle = 0;
    logic signed [31:0] i_quat_x = 0, i_quat_y = 0, i_quat_z = 0, i_quat_w = 0;
    logic signed [31:0] i_other_x = 0, i_other_y = 0, i_other_z = 0, i_other_w = 0;
    logic signed [31:0] o_out_x, o_out_y, o_out_z, o_out_w;

    quaternion_math_unit DUT (.*);

    initial forever #5 i_clk = ~i_clk;

    t_res pending_results[$];
    int errors = 0, n_checked = 0, n_sat = 0;
    int n_kind[4] = '{0, 0, 0, 0};
    longint cycles = 0;
    bit in_done = 0;

    // ---------------- predictor ----------------
    bit sat_seen;

    function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    // exact sum of products, rounded half up by 2^s, then clamped
    function automatic logic signed [63:0] round_sum(logic signed [129:0] acc, int s);
        logic signed [129:0] r;
        r = (acc + (130'sd1 <<< (s - 1))) >>> s;
        if (r > 130'sd2147483647) begin sat_seen = 1; return 64'sd2147483647; end
        if (r < -130'sd2147483648) begin sat_seen = 1; return -64'sd2147483648; end
        return r[63:0];
    endfunction

    function automatic logic signed [129:0] wide(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [129:0] wa, wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    function automatic void half_sincos(logic [15:0] ang, output logic signed [63:0] sn,
                                        output logic signed [63:0] cs);
        logic [31:0] ph;
        logic signed [63:0] x, y, z, dx, dy;
        bit flip;
        ph = 32'(ang) << 15;
        flip = 0;
        x = 64'(CORDIC_GAIN);
        y = 0;
        if (((ph + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            flip = 1;
            ph = ph - 32'h8000_0000;
        end
        z = 64'($signed(ph));
        for (int i = 0; i < STEPS && i < 31; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= 64'(f_atan(i));
            end else begin
                x += dx; y -= dy; z += 64'(f_atan(i));
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic t_res predict_quat(t_req r);
        t_res e;
        logic signed [63:0] qx, qy, qz, qw, ox, oy, oz, ow;
        logic signed [63:0] sy, cy, sp, cp, sr, cr, cysp, sycp, cycp, sysp, tx, ty, tz;
        int se;
        sat_seen = 0;
        e.typed = 0;
        for (int j = 0; j < 4; j++) e.v[j] = '0;
        qx = $signed(r.q[0]); qy = $signed(r.q[1]); qz = $signed(r.q[2]); qw = $signed(r.q[3]);
        ox = $signed(r.o[0]); oy = $signed(r.o[1]); oz = $signed(r.o[2]); ow = $signed(r.o[3]);
        case (t_kind'(r.kind))
            KIND_EULER: begin
                se = 60 - FB;
                half_sincos(r.yaw, sy, cy);
                half_sincos(r.pitch, sp, cp);
                half_sincos(r.roll, sr, cr);
                cysp = floor_shr(cy * sp + (64'sd1 <<< 29), 30);
                sycp = floor_shr(sy * cp + (64'sd1 <<< 29), 30);
                cycp = floor_shr(cy * cp + (64'sd1 <<< 29), 30);
                sysp = floor_shr(sy * sp + (64'sd1 <<< 29), 30);
                e.v[0] = 32'(round_sum(wide(cysp, cr) + wide(sycp, sr), se));
                e.v[1] = 32'(round_sum(wide(sycp, cr) - wide(cysp, sr), se));
                e.v[2] = 32'(round_sum(wide(cycp, sr) - wide(sysp, cr), se));
                e.v[3] = 32'(round_sum(wide(cycp, cr) + wide(sysp, sr), se));
            end
            KIND_HAMILTON: begin
                e.v[0] = 32'(round_sum(wide(qw, ox) + wide(qx, ow) + wide(qy, oz)
                                       - wide(qz, oy), FB));
                e.v[1] = 32'(round_sum(wide(qw, oy) - wide(qx, oz) + wide(qy, ow)
                                       + wide(qz, ox), FB));
                e.v[2] = 32'(round_sum(wide(qw, oz) + wide(qx, oy) - wide(qy, ox)
                                       + wide(qz, ow), FB));
                e.v[3] = 32'(round_sum(wide(qw, ow) - wide(qx, ox) - wide(qy, oy)
                                       - wide(qz, oz), FB));
            end
            KIND_ROTATE: begin
                tx = round_sum(wide(qy, oz) - wide(qz, oy), FB - 1);
                ty = round_sum(wide(qz, ox) - wide(qx, oz), FB - 1);
                tz = round_sum(wide(qx, oy) - wide(qy, ox), FB - 1);
                e.v[0] = 32'(round_sum((wide(ox, 64'sd1) <<< FB) + wide(tx, qw) + wide(qy, tz)
                                       - wide(qz, ty), FB));
                e.v[1] = 32'(round_sum((wide(oy, 64'sd1) <<< FB) + wide(ty, qw) + wide(qz, tx)
                                       - wide(qx, tz), FB));
                e.v[2] = 32'(round_sum((wide(oz, 64'sd1) <<< FB) + wide(tz, qw) + wide(qx, ty)
                                       - wide(qy, tx), FB));
            end
            default: ;
        endcase
        e.ovf = sat_seen;
        return e;
    endfunction

    // ---------------- stimulus ----------------
    localparam logic [31:0] MAXP = 32'h7FFF_FFFF, MINN = 32'h8000_0000, ONE = 32'h0001_0000;

    function automatic t_req mk(logic [1:0] k, logic [15:0] ya, logic [15:0] pa,
                                logic [15:0] ra, logic [31:0] q0, logic [31:0] q1,
                                logic [31:0] q2, logic [31:0] q3, logic [31:0] o0,
                                logic [31:0] o1, logic [31:0] o2, logic [31:0] o3);
        t_req r;
        r.kind = k; r.yaw = ya; r.pitch = pa; r.roll = ra;
        r.q = '{q0, q1, q2, q3};
        r.o = '{o0, o1, o2, o3};
        return r;
    endfunction

    function automatic t_res typed_res(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [31:0] w, logic ovf);
        t_res e;
        e.v = '{x, y, z, w};
        e.ovf = ovf;
        e.typed = 1;
        return e;
    endfunction

    function automatic logic [31:0] rnd_word(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
            2: return $urandom_range(0, 1) ? MAXP : MINN;
            default: return 32'($signed($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000);
        endcase
    endfunction

    function automatic t_req rnd_req();
        t_req r;
        int m;
        r.kind = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : 2'($urandom_range(0, 2));
        r.yaw = 16'($urandom); r.pitch = 16'($urandom); r.roll = 16'($urandom);
        m = $urandom_range(0, 9);
        m = (m < 3) ? 0 : (m < 7) ? 1 : (m < 8) ? 2 : 3;
        for (int j = 0; j < 4; j++) begin
            r.q[j] = rnd_word(m);
            r.o[j] = rnd_word($urandom_range(0, 1) ? m : $urandom_range(0, 3));
        end
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(t_req r, t_res typed);
        t_res e;
        e = predict_quat(r);
        if (typed.typed) begin
            if (typed.v != e.v || typed.ovf != e.ovf)
                $display("%0t: table row disagrees with predictor, kind %0d", $time, r.kind);
            e = typed;
        end
        i_valid <= 1;
        i_kind <= r.kind;
        i_yaw_angle <= r.yaw; i_pitch_angle <= r.pitch; i_roll_angle <= r.roll;
        i_quat_x <= r.q[0]; i_quat_y <= r.q[1]; i_quat_z <= r.q[2]; i_quat_w <= r.q[3];
        i_other_x <= r.o[0]; i_other_y <= r.o[1]; i_other_z <= r.o[2]; i_other_w <= r.o[3];
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(e);
        n_kind[r.kind]++;
    endtask

    t_req dir_req[$];
    t_res dir_res[$];

    initial begin
        t_res none;
        int g;
        logic [15:0] angs[8];
        none.typed = 0;
        angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
                 16'h0001, 16'h7FFF, 16'h5555};
        // identity and zero cases typed by hand; the rest rely on the predictor
        dir_req.push_back(mk(KIND_HAMILTON, 0, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE));
        dir_res.push_back(typed_res(0, 0, 0, ONE, 0));
        dir_req.push_back(mk(KIND_HAMILTON, 0, 0, 0, 0, 0, 0, 0, MAXP, MINN, MAXP, MINN));
        dir_res.push_back(typed_res(0, 0, 0, 0, 0));
        dir_req.push_back(mk(KIND_HAMILTON, 0, 0, 0, MAXP, MAXP, MAXP, MAXP,
                             MAXP, MAXP, MAXP, MAXP));
        dir_res.push_back(none);
        dir_req.push_back(mk(KIND_HAMILTON, 0, 0, 0, MINN, MINN, MINN, MINN,
                             MINN, MINN, MINN, MINN));
        dir_res.push_back(none);
        dir_req.push_back(mk(KIND_HAMILTON, 0, 0, 0, MINN, MAXP, MINN, MAXP,
                             MAXP, MINN, MINN, MAXP));
        dir_res.push_back(none);
        // vector rotation: identity quaternion leaves the vector alone, w forced to zero
        dir_req.push_back(mk(KIND_ROTATE, 0, 0, 0, 0, 0, 0, ONE, ONE, 2 * ONE, 3 * ONE, MAXP));
        dir_res.push_back(typed_res(ONE, 2 * ONE, 3 * ONE, 0, 0));
        dir_req.push_back(mk(KIND_ROTATE, 0, 0, 0, MAXP, MINN, MAXP, MINN,
                             MINN, MAXP, MINN, 0));
        dir_res.push_back(none);
        dir_req.push_back(mk(KIND_ROTATE, 0, 0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
        dir_res.push_back(none);
        dir_req.push_back(mk(KIND_ROTATE, 0, 0, 0, MINN, MINN, MINN, MINN,
                             MINN, MINN, MINN, MINN));
        dir_res.push_back(none);
        // unused kind: all zero whatever the inputs
        dir_req.push_back(mk(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, MAXP, MINN, MAXP, MINN,
                             MAXP, MINN, MAXP, MINN));
        dir_res.push_back(typed_res(0, 0, 0, 0, 0));
        // euler angles at zero, quarter, half, extreme and odd values
        dir_req.push_back(mk(KIND_EULER, 0, 0, 0, MAXP, MAXP, MAXP, MAXP, 0, 0, 0, 0));
        dir_res.push_back(none);
        for (int a = 0; a < 8; a++) begin
            dir_req.push_back(mk(KIND_EULER, angs[a], angs[(a + 3) % 8], angs[(a + 5) % 8],
                                 0, 0, 0, 0, 0, 0, 0, 0));
            dir_res.push_back(none);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (dir_req[i]) begin
            g = gap_len();
            if (g > 0) begin
                i_valid <= 0;
                repeat (g) @(posedge i_clk);
            end
            send(dir_req[i], dir_res[i]);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            g = (n % 300 < 150) ? 0 : gap_len();
            if (g > 0) begin
                i_valid <= 0;
                repeat (g) @(posedge i_clk);
            end
            send(rnd_req(), none);
        end
        i_valid <= 0;
        in_done = 1;
    end

    // output side: random stalls, with a stretch of none
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (cycles % 3000 < 800) i_ready <= 1;
            else begin
                g = gap_len();
                i_ready <= (g == 0);
                if (g > 0) repeat (g - 1) @(posedge i_clk);
            end
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_res e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h w=%h", $time,
                         o_out_x, o_out_y, o_out_z, o_out_w);
                errors++;
            end else begin
                e = pending_results.pop_front();
                n_checked++;
                if (o_overflow) n_sat++;
                if (o_out_x !== e.v[0] || o_out_y !== e.v[1] || o_out_z !== e.v[2] ||
                    o_out_w !== e.v[3] || o_overflow !== e.ovf) begin
                    $display("%0t: mismatch exp x=%h y=%h z=%h w=%h ovf=%b", $time,
                             e.v[0], e.v[1], e.v[2], e.v[3], e.ovf);
                    $display("%0t:          got x=%h y=%h z=%h w=%h ovf=%b", $time,
                             o_out_x, o_out_y, o_out_z, o_out_w, o_overflow);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (in_done && pending_results.size() == 0);
        repeat (STEPS + 20) @(posedge i_clk);
        $display("Checked %0d results (euler %0d, product %0d, rotate %0d, unused %0d)",
                 n_checked, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
        $display("%0d of them saturated; input gaps and output stalls were random",
                 n_sat);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d requests outstanding", cycles,
                 pending_results.size());
        $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: sim.f
rtl/qmu_pkg.sv
rtl/qmu_cordic.sv
rtl/qmu_dot.sv
rtl/quaternion_math_unit.sv
tb/tb.sv
